// ----- design/r2fft_pkg.sv -----
`default_nettype none
package r2fft_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int POINT_BITS  = 32;
  localparam int INDEX_BITS  = 10;
  localparam int CFG_BITS    = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_LOG2_POINTS  = 1'b0;
  localparam logic CFG_INVERSE_MODE = 1'b1;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [INDEX_BITS-1:0]         point_index;
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [POINT_BITS-1:0] point_real;
    logic signed [POINT_BITS-1:0] point_imag;
    logic [INDEX_BITS-1:0]        read_index;
    logic                         overflow_seen;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BR_RD0,
    ST_BR_RD1,
    ST_BR_WR0,
    ST_BR_WR1,
    ST_BF0,
    ST_BF1,
    ST_BF2,
    ST_BF3,
    ST_BF4,
    ST_BF5,
    ST_BF6,
    ST_BF7,
    ST_BF8
  } state_e;

  typedef enum logic [1:0] {
    MUL_BR_WR,
    MUL_BI_WI,
    MUL_BR_WI,
    MUL_BI_WR
  } mul_sel_e;

  typedef struct packed {
    logic     load_a;
    logic     load_b;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     tr_load;
    logic     ti_load;
  } bfly_ctrl_t;

  // rounded twiddle, half away from zero, frac fraction bits
  function automatic logic signed [24:0] tw_val(int m, int log2_depth, int frac, bit sine);
    real ang;
    real v;
    int  r;
    ang = 3.14159265358979323846 * m * (2.0 ** (1 - log2_depth));
    v   = (sine ? $sin(ang) : $cos(ang)) * (2.0 ** frac);
    if (v >= 0.0) begin
      r = $rtoi($floor(v + 0.5));
    end else begin
      r = -$rtoi($floor(-v + 0.5));
    end
    return 25'(r);
  endfunction

endpackage
`default_nettype wire

// ----- design/r2fft_ram.sv -----
`default_nettype none
module r2fft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/r2fft_twiddle.sv -----
`default_nettype none
module r2fft_twiddle #(
  parameter int MAX_LOG2_POINTS = 10,
  parameter int TWIDDLE_BITS    = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         inverse_i,
  input  wire logic [((MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS-1 : 1)-1:0] ix_i,
  output      logic signed [TWIDDLE_BITS:0]                 tw_re_o,
  output      logic signed [TWIDDLE_BITS:0]                 tw_im_o
);
  import r2fft_pkg::*;

  localparam int DEPTH = 1 << MAX_LOG2_POINTS;
  localparam int HALF  = DEPTH / 2;
  localparam int WW    = TWIDDLE_BITS + 1;
  localparam int FRAC  = TWIDDLE_BITS - 1;

  logic signed [WW-1:0] cos_tab [HALF];
  logic signed [WW-1:0] sin_tab [HALF];

  for (genvar g = 0; g < HALF; g++) begin : g_tab
    assign cos_tab[g] = WW'(tw_val(g, MAX_LOG2_POINTS, FRAC, 1'b0));
    assign sin_tab[g] = WW'(tw_val(g, MAX_LOG2_POINTS, FRAC, 1'b1));
  end

  // conjugate twiddle for the inverse transform
  always_ff @(posedge clk_i) begin
    tw_re_o <= cos_tab[ix_i];
    tw_im_o <= inverse_i ? -sin_tab[ix_i] : sin_tab[ix_i];
  end

endmodule
`default_nettype wire

// ----- design/r2fft_bfly.sv -----
`default_nettype none
module r2fft_bfly #(
  parameter int TWIDDLE_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire r2fft_pkg::bfly_ctrl_t        ctrl_i,
  input  wire logic [63:0]                  rdata_i,
  input  wire logic signed [TWIDDLE_BITS:0] tw_re_i,
  input  wire logic signed [TWIDDLE_BITS:0] tw_im_i,
  output      logic [63:0]                  a_o,
  output      logic [63:0]                  sum_o,
  output      logic [63:0]                  diff_o,
  output      logic                         sum_sat_o,
  output      logic                         diff_sat_o
);
  import r2fft_pkg::*;

  localparam int DW   = POINT_BITS;
  localparam int WW   = TWIDDLE_BITS + 1;
  localparam int PW   = DW + WW;
  localparam int SW   = PW + 1;
  localparam int FRAC = TWIDDLE_BITS - 1;
  localparam int TW   = SW - FRAC;
  localparam int RW   = TW + 1;

  logic [63:0]          a_q, b_q;
  logic signed [PW-1:0] prod_q, prod_d, acc_q;
  logic signed [TW-1:0] tr_q, ti_q;
  logic signed [DW-1:0] opa;
  logic signed [WW-1:0] opw;
  logic signed [SW-1:0] rsum, rdiff;
  logic signed [RW-1:0] are, aim, s_re, s_im, d_re, d_im;
  logic                 s_re_ov, s_im_ov, d_re_ov, d_im_ov;

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_BR_WR: begin opa = b_q[63:32]; opw = tw_re_i; end
      MUL_BI_WI: begin opa = b_q[31:0];  opw = tw_im_i; end
      MUL_BR_WI: begin opa = b_q[63:32]; opw = tw_im_i; end
      MUL_BI_WR: begin opa = b_q[31:0];  opw = tw_re_i; end
      default:   begin opa = b_q[63:32]; opw = tw_re_i; end
    endcase
    prod_d = PW'(opa) * PW'(opw);
  end

  // round to integer: add half an lsb, then floor
  assign rdiff = SW'(acc_q) - SW'(prod_q) + (SW'(1) <<< (FRAC - 1));
  assign rsum  = SW'(acc_q) + SW'(prod_q) + (SW'(1) <<< (FRAC - 1));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.load_a)   a_q   <= rdata_i;
    if (ctrl_i.load_b)   b_q   <= rdata_i;
    if (ctrl_i.acc_load) acc_q <= prod_q;
    if (ctrl_i.tr_load)  tr_q  <= rdiff[SW-1:FRAC];
    if (ctrl_i.ti_load)  ti_q  <= rsum[SW-1:FRAC];
  end

  assign are  = RW'($signed(a_q[63:32]));
  assign aim  = RW'($signed(a_q[31:0]));
  assign s_re = are + RW'(tr_q);
  assign s_im = aim + RW'(ti_q);
  assign d_re = are - RW'(tr_q);
  assign d_im = aim - RW'(ti_q);

  // out of range when the bits above the sign do not all match it
  assign s_re_ov = (s_re[RW-1:DW-1] != '0) && (s_re[RW-1:DW-1] != '1);
  assign s_im_ov = (s_im[RW-1:DW-1] != '0) && (s_im[RW-1:DW-1] != '1);
  assign d_re_ov = (d_re[RW-1:DW-1] != '0) && (d_re[RW-1:DW-1] != '1);
  assign d_im_ov = (d_im[RW-1:DW-1] != '0) && (d_im[RW-1:DW-1] != '1);

  function automatic logic [DW-1:0] sat(logic signed [RW-1:0] v, logic ov);
    if (!ov) begin
      return v[DW-1:0];
    end
    return v[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  assign sum_o      = {sat(s_re, s_re_ov), sat(s_im, s_im_ov)};
  assign diff_o     = {sat(d_re, d_re_ov), sat(d_im, d_im_ov)};
  assign sum_sat_o  = s_re_ov || s_im_ov;
  assign diff_sat_o = d_re_ov || d_im_ov;
  assign a_o        = a_q;

endmodule
`default_nettype wire

// ----- design/radix2_complex_fft.sv -----
// write item: stored as it is accepted; read item: store read at accept, result registered from ST_READ
// run item: bit-reversal walk over every index, two reads and two writes per swap, then
//   butterfly states ST_BF0 to ST_BF8 on the shared multiplier, log2(N) * N/2 butterflies
// the one store read port, the one write port and the one multiplier set the butterfly rate
// reset (async, active low): idle, log2_points 10, forward, flag clear;
//   point store contents undefined until written
`default_nettype none
module radix2_complex_fft #(
  parameter int MAX_LOG2_POINTS = 10,
  parameter int TWIDDLE_BITS    = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire r2fft_pkg::in_item_t            in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      r2fft_pkg::out_item_t           out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [r2fft_pkg::CFG_BITS-1:0] cfg_data_i
);
  import r2fft_pkg::*;

  localparam int AW  = MAX_LOG2_POINTS;
  localparam int LW  = $clog2(MAX_LOG2_POINTS + 1);
  localparam int IXW = (AW > 1) ? AW - 1 : 1;

  state_e          state_q, state_d;
  logic [AW-1:0]   i_q, i_d, k_q, k_d;
  logic [LW-1:0]   l_q, l_d, lg;
  logic [3:0]      log2_q;
  logic            inv_q, sat_q, sat_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;
  logic [INDEX_BITS-1:0] rd_idx_q;

  logic            in_accept;
  logic [AW+INDEX_BITS-1:0] pi_ext, idx_ext;
  logic [AW-1:0]   idx, rev, r_idx, nmask, klast, hm, half, j, bi, bp, ix_full;
  logic [AW:0]     n_full;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_rdata;

  bfly_ctrl_t      ctrl;
  logic [63:0]     a_val, sum_val, diff_val;
  logic            sum_sat, diff_sat;
  logic signed [TWIDDLE_BITS:0] tw_re, tw_im;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  assign pi_ext  = {AW'(0), in_data_i.point_index};
  assign idx     = pi_ext[AW-1:0];
  assign idx_ext = {INDEX_BITS'(0), idx};

  always_comb begin
    if (log2_q == 4'd0) begin
      lg = LW'(1);
    end else if (int'(log2_q) > MAX_LOG2_POINTS) begin
      lg = LW'(MAX_LOG2_POINTS);
    end else begin
      lg = LW'(log2_q);
    end
  end

  assign n_full = (AW+1)'(1) << lg;
  assign nmask  = AW'(n_full - (AW+1)'(1));
  assign klast  = nmask >> 1;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev[b] = i_q[AW-1-b];
    end
  end
  assign r_idx = rev >> (LW'(AW) - lg);

  // butterfly k of stage l: split into group and offset within the group
  assign half    = AW'(1) << (l_q - LW'(1));
  assign hm      = half - AW'(1);
  assign j       = k_q & hm;
  assign bi      = ((k_q & ~hm) << 1) | j;
  assign bp      = bi | half;
  assign ix_full = j << (LW'(AW) - l_q);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    l_d         = l_q;
    sat_d       = sat_q;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = {32'(in_data_i.sample_real), 32'(in_data_i.sample_imag)};
    ram_raddr   = idx;
    ctrl        = '0;
    ctrl.mul_sel = MUL_BR_WR;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.opcode)
            OP_WRITE: ram_we = 1'b1;
            OP_RUN: begin
              sat_d   = 1'b0;
              i_d     = '0;
              state_d = ST_BR_RD0;
            end
            OP_READ: state_d = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_BR_RD0: begin
        ram_raddr = i_q;
        if (i_q < r_idx) begin
          state_d = ST_BR_RD1;
        end else if (i_q == nmask) begin
          l_d     = LW'(1);
          k_d     = '0;
          state_d = ST_BF0;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      ST_BR_RD1: begin
        ram_raddr   = r_idx;
        ctrl.load_a = 1'b1;
        state_d     = ST_BR_WR0;
      end
      ST_BR_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = ST_BR_WR1;
      end
      ST_BR_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = r_idx;
        ram_wdata = a_val;
        if (i_q == nmask) begin
          l_d     = LW'(1);
          k_d     = '0;
          state_d = ST_BF0;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = ST_BR_RD0;
        end
      end
      ST_BF0: begin
        ram_raddr = bp;
        state_d   = ST_BF1;
      end
      ST_BF1: begin
        ram_raddr   = bi;
        ctrl.load_b = 1'b1;
        state_d     = ST_BF2;
      end
      ST_BF2: begin
        ctrl.load_a  = 1'b1;
        ctrl.mul_sel = MUL_BR_WR;
        state_d      = ST_BF3;
      end
      ST_BF3: begin
        ctrl.acc_load = 1'b1;
        ctrl.mul_sel  = MUL_BI_WI;
        state_d       = ST_BF4;
      end
      ST_BF4: begin
        ctrl.tr_load = 1'b1;
        ctrl.mul_sel = MUL_BR_WI;
        state_d      = ST_BF5;
      end
      ST_BF5: begin
        ctrl.acc_load = 1'b1;
        ctrl.mul_sel  = MUL_BI_WR;
        state_d       = ST_BF6;
      end
      ST_BF6: begin
        ctrl.ti_load = 1'b1;
        state_d      = ST_BF7;
      end
      ST_BF7: begin
        ram_we    = 1'b1;
        ram_waddr = bp;
        ram_wdata = diff_val;
        sat_d     = sat_q || diff_sat;
        state_d   = ST_BF8;
      end
      ST_BF8: begin
        ram_we    = 1'b1;
        ram_waddr = bi;
        ram_wdata = sum_val;
        sat_d     = sat_q || sum_sat;
        if (k_q != klast) begin
          k_d     = k_q + AW'(1);
          state_d = ST_BF0;
        end else if (l_q != lg) begin
          k_d     = '0;
          l_d     = l_q + LW'(1);
          state_d = ST_BF0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      l_q         <= LW'(1);
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      log2_q      <= 4'd10;
      inv_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      l_q         <= l_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LOG2_POINTS:  log2_q <= cfg_data_i;
          CFG_INVERSE_MODE: inv_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      rd_idx_q <= idx_ext[INDEX_BITS-1:0];
    end
    if (state_q == ST_READ) begin
      out_q.point_real    <= ram_rdata[63:32];
      out_q.point_imag    <= ram_rdata[31:0];
      out_q.read_index    <= rd_idx_q;
      out_q.overflow_seen <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  r2fft_ram #(
    .WIDTH(64),
    .DEPTH(1 << MAX_LOG2_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  r2fft_twiddle #(
    .MAX_LOG2_POINTS(MAX_LOG2_POINTS),
    .TWIDDLE_BITS   (TWIDDLE_BITS)
  ) u_twiddle (
    .clk_i    (clk_i),
    .inverse_i(inv_q),
    .ix_i     (ix_full[IXW-1:0]),
    .tw_re_o  (tw_re),
    .tw_im_o  (tw_im)
  );

  r2fft_bfly #(
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_bfly (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rdata_i   (ram_rdata),
    .tw_re_i   (tw_re),
    .tw_im_i   (tw_im),
    .a_o       (a_val),
    .sum_o     (sum_val),
    .diff_o    (diff_val),
    .sum_sat_o (sum_sat),
    .diff_sat_o(diff_sat)
  );

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_READ))
    else $error("result appeared without a read");

  a_store_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE || state_q == ST_BR_WR0 || state_q == ST_BR_WR1 ||
                state_q == ST_BF7 || state_q == ST_BF8))
    else $error("store written outside a write step");

  a_run_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.opcode == OP_RUN) |=> (state_q == ST_BR_RD0 && !sat_q))
    else $error("run item did not start a clean transform");

  a_stage_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BF0) |-> (l_q != '0 && l_q <= lg && k_q <= klast))
    else $error("butterfly counters out of range");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import r2fft_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int MAX_LOG2    = 10;
  localparam int TW_FRAC     = 15;
  localparam int QUIET_LIMIT = 250000;
  localparam int ITEM_GOAL   = 1400;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [1:0]  OP_NONE = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_data_o;

  int          tw_cos [DEPTH/2];
  int          tw_sin [DEPTH/2];
  int          pt_re [DEPTH];
  int          pt_im [DEPTH];
  bit          written [DEPTH];
  bit          sat_flag;
  int unsigned cur_log2;
  bit          cur_inv;
  out_item_t   pending_points[$];
  dir_row_t    rows[$];
  int          errors, reads_checked, runs_done, sat_runs, items_sent, quiet, hold_cnt;
  bit          calm, press_req, press_done;

  radix2_complex_fft dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  // twiddle table in q60 fixed point, rounded to q1.15
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic void cos_sin_series(input logic [63:0] x, output logic [63:0] c,
                                         output logic [63:0] s);
    logic [63:0] cp, cn, sp, sn, term;
    cp = ONE_Q60; cn = 0; sp = 0; sn = 0; term = ONE_Q60;
    for (int k = 1; k <= 26; k++) begin
      term = mul_q60(term, x) / k;
      if (k % 2) begin
        if (((k - 1) / 2) % 2) sn += term;
        else sp += term;
      end else begin
        if ((k / 2) % 2) cn += term;
        else cp += term;
      end
    end
    c = cp - cn;
    s = sp - sn;
  endfunction

  function automatic int round_tw(input logic [63:0] v);
    logic [63:0] w;
    w = (v + (64'd1 << (59 - TW_FRAC))) >> (60 - TW_FRAC);
    return int'(w);
  endfunction

  function automatic void build_twiddles();
    int unsigned r;
    logic [63:0] c, s;
    bit neg;
    for (int m = 0; m < DEPTH / 2; m++) begin
      r = m;
      neg = 0;
      if (4 * m > DEPTH) begin
        r = DEPTH / 2 - m;
        neg = 1;
      end
      if (8 * r <= DEPTH) begin
        cos_sin_series(mul_q60(PI_Q60, 64'(2 * r) << (60 - MAX_LOG2)), c, s);
      end else begin
        cos_sin_series(mul_q60(PI_Q60, 64'(2 * (DEPTH / 4 - r)) << (60 - MAX_LOG2)), s, c);
      end
      tw_cos[m] = neg ? -round_tw(c) : round_tw(c);
      tw_sin[m] = round_tw(s);
    end
  endfunction

  function automatic int sat32(input longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic int unsigned bit_reverse(input int unsigned i, input int unsigned bits);
    int unsigned r;
    r = 0;
    for (int b = 0; b < bits; b++) r = (r << 1) | ((i >> b) & 1);
    return r;
  endfunction

  function automatic int unsigned eff_log2(input int unsigned lg);
    if (lg < 1) return 1;
    if (lg > MAX_LOG2) return MAX_LOG2;
    return lg;
  endfunction

  function automatic void transform_store();
    int unsigned lg, n, r, half, span, ix, p;
    longint wr, wi, br, bi, tr, ti, ar, ai;
    int tmp;
    lg = eff_log2(cur_log2);
    n = 1 << lg;
    sat_flag = 0;
    for (int unsigned i = 0; i < n; i++) begin
      r = bit_reverse(i, lg);
      if (i < r) begin
        tmp = pt_re[i]; pt_re[i] = pt_re[r]; pt_re[r] = tmp;
        tmp = pt_im[i]; pt_im[i] = pt_im[r]; pt_im[r] = tmp;
      end
    end
    for (int unsigned l = 1; l <= lg; l++) begin
      half = 1 << (l - 1);
      span = half << 1;
      for (int unsigned j = 0; j < half; j++) begin
        ix = j << (MAX_LOG2 - l);
        wr = tw_cos[ix];
        wi = cur_inv ? -longint'(tw_sin[ix]) : longint'(tw_sin[ix]);
        if (ix == 0) begin
          wr = 64'sd1 <<< TW_FRAC;
          wi = 0;
        end
        for (int unsigned i = j; i < n; i += span) begin
          p = i + half;
          br = pt_re[p];
          bi = pt_im[p];
          tr = (br * wr - bi * wi + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
          ti = (br * wi + bi * wr + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
          ar = pt_re[i];
          ai = pt_im[i];
          pt_re[p] = sat32(ar - tr);
          pt_im[p] = sat32(ai - ti);
          pt_re[i] = sat32(ar + tr);
          pt_im[i] = sat32(ai + ti);
        end
      end
    end
  endfunction

  function automatic void predict_point(input in_item_t it);
    out_item_t o;
    case (it.opcode)
      OP_WRITE: begin
        pt_re[it.point_index] = int'(it.sample_real);
        pt_im[it.point_index] = int'(it.sample_imag);
        written[it.point_index] = 1;
      end
      OP_RUN: begin
        transform_store();
        runs_done++;
        if (sat_flag) sat_runs++;
      end
      OP_READ: begin
        o.point_real = pt_re[it.point_index];
        o.point_imag = pt_im[it.point_index];
        o.read_index = it.point_index;
        o.overflow_seen = sat_flag;
        pending_points.push_back(o);
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] op, input int unsigned idx,
                                       input int re, input int im);
    in_item_t it;
    it.opcode = op;
    it.point_index = INDEX_BITS'(idx);
    it.sample_real = SAMPLE_BITS'(re);
    it.sample_imag = SAMPLE_BITS'(im);
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input int re,
                                  input int im, input bit ovf);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want.point_real = re;
    row.want.point_imag = im;
    row.want.read_index = it.point_index;
    row.want.overflow_seen = ovf;
    rows.push_back(row);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_point(it);
    if (typed) pending_points[pending_points.size() - 1] = want;
    if (it.opcode != OP_NONE) items_sent++;
  endtask

  task automatic send_plain(input in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned lg, input bit inv);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LOG2_POINTS;
    cfg_data_i  <= CFG_BITS'(lg);
    @(posedge clk_i);
    cfg_index_i <= CFG_INVERSE_MODE;
    cfg_data_i  <= CFG_BITS'(inv);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_log2 = lg;
    cur_inv  = inv;
    @(posedge clk_i);
  endtask

  function automatic int rand_sample(input bit full);
    if (full) return int'($urandom);
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  // receiver: random stalls plus one long hold to back the block up
  always @(posedge clk_i) begin
    if (press_req && !press_done) begin
      press_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point item idx %0d", $time, out_data_o.read_index);
      end else begin
        want = pending_points.pop_front();
        reads_checked++;
        if (out_data_o.point_real !== want.point_real) begin
          errors++;
          $display("%0t: point_real exp %0d act %0d", $time, want.point_real,
                   out_data_o.point_real);
        end
        if (out_data_o.point_imag !== want.point_imag) begin
          errors++;
          $display("%0t: point_imag exp %0d act %0d", $time, want.point_imag,
                   out_data_o.point_imag);
        end
        if (out_data_o.read_index !== want.read_index) begin
          errors++;
          $display("%0t: read_index exp %0d act %0d", $time, want.read_index,
                   out_data_o.read_index);
        end
        if (out_data_o.overflow_seen !== want.overflow_seen) begin
          errors++;
          $display("%0t: overflow_seen exp %0b act %0b", $time, want.overflow_seen,
                   out_data_o.overflow_seen);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned lg, n, idx, nreads;
    bit full, inv;
    int phase;
    build_twiddles();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two-point transform of the sample extremes, readable by hand
    set_config(1, 0);
    add_row(mk_item(OP_WRITE, 0, 8388607, -8388608), 0, 0, 0, 0);
    add_row(mk_item(OP_WRITE, 1, -8388608, 8388607), 0, 0, 0, 0);
    add_row(mk_item(OP_WRITE, 1023, -1, 1), 0, 0, 0, 0);
    add_row(mk_item(OP_READ, 0, 0, 0), 1, 8388607, -8388608, 0);
    add_row(mk_item(OP_READ, 1023, 0, 0), 1, -1, 1, 0);
    add_row(mk_item(OP_NONE, 5, 123, -45), 0, 0, 0, 0);
    add_row(mk_item(OP_RUN, 777, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(OP_READ, 0, 0, 0), 1, -1, -1, 0);
    add_row(mk_item(OP_READ, 1, 0, 0), 1, 16777215, -16777215, 0);
    add_row(mk_item(OP_READ, 1023, 0, 0), 1, -1, 1, 0);
    add_row(mk_item(OP_WRITE, 2, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(OP_WRITE, 3, -8388608, -8388608), 0, 0, 0, 0);
    add_row(mk_item(OP_READ, 3, 0, 0), 1, -8388608, -8388608, 0);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase)
        0: lg = 0;
        1: lg = 15;
        2: lg = 11;
        default: begin
          idx = $urandom_range(99);
          if (idx < 70) lg = $urandom_range(1, 5);
          else if (idx < 92) lg = $urandom_range(6, 8);
          else lg = 9;
        end
      endcase
      inv = $urandom_range(1);
      drain();
      calm = (phase >= 4 && phase <= 7);
      set_config(lg, inv);
      n = 1 << eff_log2(lg);
      full = ($urandom_range(9) < 4);
      // large transforms rewrite only a sprinkle of their already written points
      for (int unsigned i = 0; i < n; i++) begin
        if (!written[i] || (n <= 64 && $urandom_range(3) != 0) || $urandom_range(15) == 0)
          send_plain(mk_item(OP_WRITE, i, rand_sample(full), rand_sample(full)));
        if ($urandom_range(49) == 0)
          send_plain(mk_item(OP_NONE, $urandom_range(1023), int'($urandom), int'($urandom)));
        if ($urandom_range(29) == 0)
          send_plain(mk_item(OP_WRITE, $urandom_range(1023), rand_sample(1), rand_sample(1)));
      end
      // a few phases read without running, some run twice
      if ($urandom_range(9) != 0) send_plain(mk_item(OP_RUN, $urandom_range(1023), 0, 0));
      if ($urandom_range(9) == 0) send_plain(mk_item(OP_RUN, $urandom_range(1023), 0, 0));
      nreads = (phase == 3) ? 40 : $urandom_range(3, 10);
      for (int r = 0; r < nreads; r++) begin
        do idx = $urandom_range(1023); while (!written[idx]);
        send_plain(mk_item(OP_READ, idx, int'($urandom), int'($urandom)));
        // hold the receiver once the run is over and reads are queuing
        if (phase == 3 && r == 0) press_req = 1;
      end
      phase++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d items in %0d phases: %0d transforms (%0d saturating), %0d points read",
             items_sent, phase, runs_done, sat_runs, reads_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- radix2_complex_fft.f -----
design/r2fft_pkg.sv
design/r2fft_ram.sv
design/r2fft_twiddle.sv
design/r2fft_bfly.sv
design/radix2_complex_fft.sv
tb/sv/testbench.sv
